// ===== design/i2cms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants for the tick-driven I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

	// Bus command codes carried in the operation field.
	typedef enum logic [2:0] {
		CMD_NONE     = 3'd0,
		CMD_START_WR = 3'd1,
		CMD_START_RD = 3'd2,
		CMD_WRITE    = 3'd3,
		CMD_READ     = 3'd4,
		CMD_STOP     = 3'd5
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_SLAVE_ADDRESS   = 1'b0,
		REG_TICKS_PER_PHASE = 1'b1
	} reg_idx_t;

	// Sub-step of a read bit: raise the clock, sample, lower the clock.
	typedef enum logic [1:0] {
		RD_RAISE  = 2'd0,
		RD_SAMPLE = 2'd1,
		RD_LOWER  = 2'd2
	} rd_sub_t;

	localparam logic [6:0]  SLAVE_ADDR_RESET = 7'h20;
	localparam logic [15:0] TPP_RESET        = 16'd1;

	// Phases in the start condition that precedes the address byte and ack clock.
	localparam logic [4:0] START_PHASES = 5'd4;
	// Phases of the data bits in a read; the master ack follows.
	localparam logic [4:0] READ_BIT_PHASES = 5'd24;
	localparam logic [4:0] READ_ACK_DRIVE  = 5'd24;
	localparam logic [4:0] READ_ACK_RAISE  = 5'd25;

	// Total phases of each command.
	function automatic logic [4:0] total_phases(input cmd_t cmd);
		logic [4:0] n;
		case (cmd)
			CMD_START_WR, CMD_START_RD: n = 5'd22;
			CMD_WRITE:                  n = 5'd18;
			CMD_READ:                   n = 5'd27;
			default:                    n = 5'd4;
		endcase
		return n;
	endfunction

	// Position of a read phase within its bit (phase modulo three).
	function automatic rd_sub_t read_sub(input logic [4:0] q);
		rd_sub_t s;
		case (q) inside
			5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24, 5'd27,
			5'd30: s = RD_RAISE;
			5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22, 5'd25, 5'd28,
			5'd31: s = RD_SAMPLE;
			default: s = RD_LOWER;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// ===== design/i2c_master_bit_sequencer.sv =====
// The result beat for a tick is registered and appears in the cycle after the tick is taken.
// Throughput: one tick per clock cycle; a tick is taken whenever the result register
// is empty or its beat is being taken in the same cycle.
// Each bus phase lasts ticks_per_phase ticks (zero acts as one), counted in a 16-bit tick counter.
// Reset (arst_n low, asynchronous) releases both lines, idles the sequencer,
// clears the held read byte and restores the address 0x20 and one tick per phase.
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Open-drain I2C master sequencer. Each input beat is one phase tick carrying
// the sampled SDA level and, while idle, an optional bus command.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// Tick input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  operation,
	input  wire logic [7:0]  tx_byte,
	input  wire logic        send_nack,
	input  wire logic        sda_in,
	// Result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             scl_pull_low,
	output logic             sda_pull_low,
	output logic [7:0]       rx_byte,
	output logic             rx_valid,
	output logic             busy_res
);

	// Configuration registers
	logic [6:0]  slave_q;
	logic [15:0] tpp_q;
	logic [15:0] tpp_eff;

	// Sequencer state
	i2cms_pkg::cmd_t cmd_q, cmd_n;
	logic [4:0]  phase_q, phase_n;
	logic [15:0] tick_q, tick_n;
	logic [7:0]  shift_q, shift_n;
	logic        scl_q, scl_n;
	logic        sda_q, sda_n;
	logic        nack_q, nack_n;
	logic [7:0]  rx_hold_q, rx_hold_n;
	logic        rxv_n;

	// Result register handshake
	logic out_valid_q;
	logic rxv_q;
	logic in_accept;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;
	assign tpp_eff   = (tpp_q == 16'd0) ? 16'd1 : tpp_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= i2cms_pkg::SLAVE_ADDR_RESET;
			tpp_q   <= i2cms_pkg::TPP_RESET;
		end else if (cfg_we) begin
			unique case (i2cms_pkg::reg_idx_t'(cfg_index))
				i2cms_pkg::REG_SLAVE_ADDRESS:   slave_q <= cfg_data[6:0];
				i2cms_pkg::REG_TICKS_PER_PHASE: tpp_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state for one tick: command launch, phase entry, tick and phase count.
	always_comb begin
		logic [15:0] tick_sum;
		logic [4:0]  phase_inc;
		logic [4:0]  wq;
		logic [3:0]  wb;
		logic        start;

		cmd_n     = cmd_q;
		phase_n   = phase_q;
		tick_n    = tick_q;
		shift_n   = shift_q;
		scl_n     = scl_q;
		sda_n     = sda_q;
		nack_n    = nack_q;
		rx_hold_n = rx_hold_q;
		rxv_n     = 1'b0;
		tick_sum  = '0;
		phase_inc = '0;
		wq        = '0;
		wb        = '0;

		// A valid command is taken only while idle; unknown codes are dropped.
		start = (cmd_q == i2cms_pkg::CMD_NONE) &&
			(operation >= i2cms_pkg::CMD_START_WR) && (operation <= i2cms_pkg::CMD_STOP);
		if (start) begin
			cmd_n   = i2cms_pkg::cmd_t'(operation);
			phase_n = '0;
			tick_n  = '0;
			case (i2cms_pkg::cmd_t'(operation))
				i2cms_pkg::CMD_START_WR: shift_n = {slave_q, 1'b0};
				i2cms_pkg::CMD_START_RD: shift_n = {slave_q, 1'b1};
				i2cms_pkg::CMD_WRITE:    shift_n = tx_byte;
				i2cms_pkg::CMD_READ: begin
					shift_n = '0;
					nack_n  = send_nack;
				end
				default: ;
			endcase
		end

		if (cmd_n != i2cms_pkg::CMD_NONE) begin
			// Line changes of a phase take effect on its first tick.
			if (tick_n == 16'd0) begin
				unique case (cmd_n)
					i2cms_pkg::CMD_START_WR, i2cms_pkg::CMD_START_RD,
					i2cms_pkg::CMD_WRITE: begin
						if ((cmd_n != i2cms_pkg::CMD_WRITE) &&
							(phase_n < i2cms_pkg::START_PHASES)) begin
							unique case (phase_n[1:0])
								2'd0: sda_n = 1'b0;
								2'd1: scl_n = 1'b0;
								2'd2: sda_n = 1'b1;
								default: scl_n = 1'b1;
							endcase
						end else begin
							// Write bit: two phases per bit, then the ack clock.
							wq = (cmd_n == i2cms_pkg::CMD_WRITE) ? phase_n :
								phase_n - i2cms_pkg::START_PHASES;
							wb = wq[4:1];
							if (wq[0]) begin
								scl_n = 1'b1;
							end else begin
								if (!wb[3]) begin
									sda_n = !shift_n[~wb[2:0]];
								end else begin
									sda_n = 1'b0;
								end
								scl_n = 1'b0;
							end
						end
					end
					i2cms_pkg::CMD_READ: begin
						if (phase_n < i2cms_pkg::READ_BIT_PHASES) begin
							unique case (i2cms_pkg::read_sub(phase_n))
								i2cms_pkg::RD_RAISE: begin
									sda_n = 1'b0;
									scl_n = 1'b0;
								end
								i2cms_pkg::RD_SAMPLE: shift_n = {shift_n[6:0], sda_in};
								default: scl_n = 1'b1;
							endcase
						end else if (phase_n == i2cms_pkg::READ_ACK_DRIVE) begin
							sda_n = !nack_n;
						end else if (phase_n == i2cms_pkg::READ_ACK_RAISE) begin
							scl_n = 1'b0;
						end else begin
							scl_n = 1'b1;
						end
					end
					default: begin
						// Stop condition.
						unique case (phase_n[1:0])
							2'd0: scl_n = 1'b1;
							2'd1: sda_n = 1'b1;
							2'd2: scl_n = 1'b0;
							default: sda_n = 1'b0;
						endcase
					end
				endcase
			end

			// Count ticks of the phase and step to the next phase.
			tick_sum = tick_n + 16'd1;
			if ((tick_sum >= tpp_eff) || (tick_sum == 16'd0)) begin
				tick_n    = '0;
				phase_inc = phase_n + 5'd1;
				if (phase_inc >= i2cms_pkg::total_phases(cmd_n)) begin
					if (cmd_n == i2cms_pkg::CMD_READ) begin
						sda_n     = 1'b0;
						rx_hold_n = shift_n;
						rxv_n     = 1'b1;
					end
					cmd_n   = i2cms_pkg::CMD_NONE;
					phase_n = '0;
				end else begin
					phase_n = phase_inc;
				end
			end else begin
				tick_n = tick_sum;
			end
		end
	end

	// State update on each accepted tick; the state doubles as the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= i2cms_pkg::CMD_NONE;
			phase_q   <= '0;
			tick_q    <= '0;
			shift_q   <= '0;
			scl_q     <= 1'b0;
			sda_q     <= 1'b0;
			nack_q    <= 1'b0;
			rx_hold_q <= '0;
			rxv_q     <= 1'b0;
		end else if (in_accept) begin
			cmd_q     <= cmd_n;
			phase_q   <= phase_n;
			tick_q    <= tick_n;
			shift_q   <= shift_n;
			scl_q     <= scl_n;
			sda_q     <= sda_n;
			nack_q    <= nack_n;
			rx_hold_q <= rx_hold_n;
			rxv_q     <= rxv_n;
		end
	end

	// Result beat valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign scl_pull_low = scl_q;
	assign sda_pull_low = sda_q;
	assign rx_byte      = rx_hold_q;
	assign rx_valid     = rxv_q;
	assign busy_res     = (cmd_q != i2cms_pkg::CMD_NONE);

`ifndef NO_ASSERTIONS
	// A completed read ends the command and leaves SDA released.
	a_rx_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rxv_q |-> (!busy_res && !sda_q))
		else $error("read completion while busy or SDA held");

	// An idle sequencer has its phase and tick counters at zero.
	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q == i2cms_pkg::CMD_NONE) |-> ((phase_q == 5'd0) && (tick_q == 16'd0)))
		else $error("counters not cleared while idle");

	// The phase never runs past the end of the running command.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q != i2cms_pkg::CMD_NONE) |-> (phase_q < i2cms_pkg::total_phases(cmd_q)))
		else $error("phase beyond command length");

	// The tick counter stays below the phase length.
	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q != i2cms_pkg::CMD_NONE) && $stable(tpp_q) |-> (tick_q < tpp_eff))
		else $error("tick counter beyond phase length");

	// State changes only on an accepted beat.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_accept |=> ($stable(phase_q) && $stable(tick_q) && $stable(rx_hold_q)))
		else $error("state moved without an accepted beat");
`endif

endmodule
`default_nettype wire
